@@ design/mapm_pkg.sv @@
// Shared types, constants and helper functions of the multichannel audio peak meter.
// Depends on nothing; every other file of the block imports it.

package mapm_pkg;

   // Field widths of the channels.
   localparam int SAMPLE_W    = 32;
   localparam int INDEX_W     = 3;
   localparam int LEVEL_W     = 17;
   localparam int REG_INDEX_W = 4;
   localparam int CSR_DATA_W  = 32;
   localparam int COUNT_W     = 4;
   localparam int FMT_W       = 3;

   // Datapath widths: magnitudes are 32 bits, the level numerator needs 49.
   localparam int MAG_W     = 32;
   localparam int NUM_W     = 49;
   localparam int DIV_STEPS = 17;
   localparam int STEP_W    = 5;

   localparam logic [COUNT_W-1:0] COUNT_RESET = 4'd2;
   localparam logic [LEVEL_W-1:0] LEVEL_ONE   = 17'h10000;

   // Register indexes of the configuration port.
   localparam logic [REG_INDEX_W-1:0] REG_SAMPLE_FORMAT = 4'd0;
   localparam logic [REG_INDEX_W-1:0] REG_CHANNEL_COUNT = 4'd1;

   // Sample formats.
   typedef enum logic [FMT_W-1:0] {
      FMT_U8      = 3'd0,
      FMT_U16     = 3'd1,
      FMT_U32     = 3'd2,
      FMT_S8      = 3'd3,
      FMT_S16     = 3'd4,
      FMT_S32     = 3'd5,
      FMT_F32     = 3'd6,
      FMT_INVALID = 3'd7
   } format_type;

   // Full-scale divisors. Float levels are |x| in Q2.30 times 100000
   // divided by 100003 * 2^14, i.e. x / 1.00003 in Q1.16.
   localparam logic [MAG_W-1:0] FS_U8   = 32'd255;
   localparam logic [MAG_W-1:0] FS_U16  = 32'd65535;
   localparam logic [MAG_W-1:0] FS_U32  = 32'hFFFF_FFFF;
   localparam logic [MAG_W-1:0] FS_S8   = 32'd127;
   localparam logic [MAG_W-1:0] FS_S16  = 32'd32767;
   localparam logic [MAG_W-1:0] FS_S32  = 32'h7FFF_FFFF;
   localparam logic [MAG_W-1:0] FS_F32  = 32'd1638449152;
   localparam logic [MAG_W-1:0] FLOAT_SCALE = 32'd100000;

   // A quotient above 1.0 happens exactly when the numerator reaches 65537 * divisor.
   localparam logic [NUM_W-1:0] SAT_MUL = 49'd65537;
   localparam logic [NUM_W-1:0] SAT_U8  = NUM_W'(FS_U8)  * SAT_MUL;
   localparam logic [NUM_W-1:0] SAT_U16 = NUM_W'(FS_U16) * SAT_MUL;
   localparam logic [NUM_W-1:0] SAT_U32 = NUM_W'(FS_U32) * SAT_MUL;
   localparam logic [NUM_W-1:0] SAT_S8  = NUM_W'(FS_S8)  * SAT_MUL;
   localparam logic [NUM_W-1:0] SAT_S16 = NUM_W'(FS_S16) * SAT_MUL;
   localparam logic [NUM_W-1:0] SAT_S32 = NUM_W'(FS_S32) * SAT_MUL;
   localparam logic [NUM_W-1:0] SAT_F32 = NUM_W'(FS_F32) * SAT_MUL;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic accept;
      logic update;
      logic emit_start;
      logic emit_read;
      logic emit_num;
      logic div_init;
      logic div_step;
      logic out_load;
   } ctrl_cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic last_item;
      logic emit_last;
      logic div_last;
      logic out_free;
   } ctrl_status_type;

   // Sample magnitude with its usable flag.
   typedef struct packed {
      logic             ok;
      logic [MAG_W-1:0] mag;
   } magnitude_type;

   // Divisor of the level division for a format.
   function automatic logic [MAG_W-1:0] full_scale(input format_type fmt);
      logic [MAG_W-1:0] fs;
      case (fmt)
         FMT_U8:  fs = FS_U8;
         FMT_U16: fs = FS_U16;
         FMT_U32: fs = FS_U32;
         FMT_S8:  fs = FS_S8;
         FMT_S16: fs = FS_S16;
         FMT_S32: fs = FS_S32;
         FMT_F32: fs = FS_F32;
         default: fs = 32'd1;
      endcase
      return fs;
   endfunction

   // Saturation threshold of the level numerator for a format.
   function automatic logic [NUM_W-1:0] sat_limit(input format_type fmt);
      logic [NUM_W-1:0] lim;
      case (fmt)
         FMT_U8:  lim = SAT_U8;
         FMT_U16: lim = SAT_U16;
         FMT_U32: lim = SAT_U32;
         FMT_S8:  lim = SAT_S8;
         FMT_S16: lim = SAT_S16;
         FMT_S32: lim = SAT_S32;
         FMT_F32: lim = SAT_F32;
         default: lim = '0;
      endcase
      return lim;
   endfunction

endpackage

@@ design/mapm_channels.sv @@
// Channel interfaces of the peak meter: sample input, level output, register writes.
// Depends on mapm_pkg for the field widths.

interface mapm_req_if;
   import mapm_pkg::*;
   logic                valid;
   logic                ready;
   logic [SAMPLE_W-1:0] sample_bits;
   logic                end_of_buffer;

   modport source (output valid, sample_bits, end_of_buffer, input ready);
   modport sink   (input valid, sample_bits, end_of_buffer, output ready);
endinterface

interface mapm_rsp_if;
   import mapm_pkg::*;
   logic               valid;
   logic               ready;
   logic [INDEX_W-1:0] channel_index;
   logic [LEVEL_W-1:0] peak_level;
   logic               last_level;

   modport source (output valid, channel_index, peak_level, last_level, input ready);
   modport sink   (input valid, channel_index, peak_level, last_level, output ready);
endinterface

interface mapm_csr_if;
   import mapm_pkg::*;
   logic                   valid;
   logic                   ready;
   logic [REG_INDEX_W-1:0] reg_index;
   logic [CSR_DATA_W-1:0]  write_data;

   modport source (output valid, reg_index, write_data, input ready);
   modport sink   (input valid, reg_index, write_data, output ready);
endinterface

@@ design/mapm_controller.sv @@
// Sequencer of the peak meter: item accept, max update and the per-channel emit pass.
// Depends on mapm_pkg for the command and status structs.

module mapm_controller (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   output logic                      req_ready,
   input  mapm_pkg::ctrl_status_type status,
   output mapm_pkg::ctrl_cmd_type    cmd
);
   import mapm_pkg::*;

   typedef enum logic [6:0] {
      ST_IDLE     = 7'b0000001,
      ST_UPDATE   = 7'b0000010,
      ST_EMIT_RD  = 7'b0000100,
      ST_EMIT_NUM = 7'b0001000,
      ST_EMIT_SAT = 7'b0010000,
      ST_EMIT_DIV = 7'b0100000,
      ST_EMIT_OUT = 7'b1000000
   } state_type;

   state_type state_ff;
   state_type state_in;

   // Next state and commands.
   always_comb begin
      state_in  = state_ff;
      cmd       = '0;
      req_ready = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.accept = 1'b1;
               state_in   = ST_UPDATE;
            end
         end
         ST_UPDATE: begin
            cmd.update = 1'b1;
            if (status.last_item) begin
               cmd.emit_start = 1'b1;
               state_in       = ST_EMIT_RD;
            end else begin
               state_in = ST_IDLE;
            end
         end
         ST_EMIT_RD: begin
            cmd.emit_read = 1'b1;
            state_in      = ST_EMIT_NUM;
         end
         ST_EMIT_NUM: begin
            cmd.emit_num = 1'b1;
            state_in     = ST_EMIT_SAT;
         end
         ST_EMIT_SAT: begin
            cmd.div_init = 1'b1;
            state_in     = ST_EMIT_DIV;
         end
         ST_EMIT_DIV: begin
            cmd.div_step = 1'b1;
            if (status.div_last) begin
               state_in = ST_EMIT_OUT;
            end
         end
         ST_EMIT_OUT: begin
            if (status.out_free) begin
               cmd.out_load = 1'b1;
               state_in     = status.emit_last ? ST_IDLE : ST_EMIT_RD;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // State register.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

@@ design/mapm_datapath.sv @@
// Datapath of the peak meter: registers, channel max memory, level divider, output register.
// Depends on mapm_pkg for widths, formats, divisors and the command and status structs.

module mapm_datapath #(
   parameter int MAX_CHANNELS = 8
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  mapm_pkg::ctrl_cmd_type               cmd,
   output mapm_pkg::ctrl_status_type            status,
   input  logic [mapm_pkg::SAMPLE_W-1:0]        sample_bits,
   input  logic                                 end_of_buffer,
   input  logic                                 csr_write,
   input  logic [mapm_pkg::REG_INDEX_W-1:0]     csr_reg_index,
   input  logic [mapm_pkg::CSR_DATA_W-1:0]      csr_write_data,
   input  logic                                 rsp_ready,
   output logic                                 rsp_valid,
   output logic [mapm_pkg::INDEX_W-1:0]         channel_index,
   output logic [mapm_pkg::LEVEL_W-1:0]         peak_level,
   output logic                                 last_level
);
   import mapm_pkg::*;

   localparam int POS_W = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1;
   localparam int CNT_W = $clog2(MAX_CHANNELS + 1);

   // Configuration registers.
   format_type         fmt_ff;
   logic [COUNT_W-1:0] count_ff;

   // Position and item registers.
   logic [POS_W-1:0]  pos_ff;
   logic [POS_W-1:0]  pos_in;
   logic [POS_W-1:0]  eff_pos;
   logic [CNT_W-1:0]  active_n;
   logic [CNT_W-1:0]  pos_plus;
   logic [POS_W-1:0]  addr_ff;
   logic [MAG_W-1:0]  mag_ff;
   logic              ok_ff;
   logic              last_ff;
   magnitude_type     sample_mag;

   // Channel max memory with one valid bit per entry.
   logic [MAG_W-1:0]        channel_max_mem [MAX_CHANNELS];
   logic [MAX_CHANNELS-1:0] valid_ff;
   logic [MAG_W-1:0]        rd_ff;
   logic [POS_W-1:0]        rd_addr;
   logic [MAG_W-1:0]        cur_max;
   logic                    upd_write;
   logic                    clear;

   // Emit pass and divider.
   logic [POS_W-1:0]   emit_ff;
   logic               emit_last;
   logic [MAG_W-1:0]   emit_max;
   logic [MAG_W-1:0]   fs;
   logic [MAG_W:0]     two_m;
   logic [MAG_W:0]     fs_ext;
   logic [MAG_W:0]     diff;
   logic [NUM_W-1:0]   num_in;
   logic [NUM_W-1:0]   num_ff;
   logic [NUM_W-1:0]   rem_ff;
   logic [NUM_W-1:0]   trial;
   logic [LEVEL_W-1:0] q_ff;
   logic [STEP_W-1:0]  step_ff;
   logic               sat_ff;
   logic [LEVEL_W-1:0] level;
   logic [POS_W+INDEX_W-1:0] emit_wide;

   // Output register.
   logic               rsp_valid_ff;
   logic [INDEX_W-1:0] index_ff;
   logic [LEVEL_W-1:0] level_ff;
   logic               last_out_ff;

   // Float32 bit pattern to |x| in unsigned Q2.30, truncated and saturated.
   function automatic magnitude_type float_q230(input logic [SAMPLE_W-1:0] bits);
      magnitude_type r;
      logic [7:0]    ex;
      logic [22:0]   man;
      logic [23:0]   sig;
      logic [7:0]    sh;
      ex    = bits[30:23];
      man   = bits[22:0];
      sig   = {1'b1, man};
      r.ok  = 1'b1;
      r.mag = '0;
      sh    = '0;
      if (ex == 8'hFF) begin
         if (man != '0) begin
            r.ok = 1'b0;
         end else begin
            r.mag = '1;
         end
      end else if (ex == 8'h00) begin
         r.mag = '0;
      end else if (ex >= 8'd120) begin
         sh = ex - 8'd120;
         if (sh > 8'd8) begin
            r.mag = '1;
         end else begin
            r.mag = MAG_W'(sig) << sh[3:0];
         end
      end else begin
         sh = 8'd120 - ex;
         if (sh >= 8'd32) begin
            r.mag = '0;
         end else begin
            r.mag = MAG_W'(sig) >> sh[4:0];
         end
      end
      return r;
   endfunction

   // Magnitude of a raw sample in the given format.
   function automatic magnitude_type sample_magnitude(input format_type fmt,
                                                      input logic [SAMPLE_W-1:0] bits);
      magnitude_type r;
      r.ok  = 1'b1;
      r.mag = '0;
      case (fmt)
         FMT_U8:  r.mag = MAG_W'(bits[7:0]);
         FMT_U16: r.mag = MAG_W'(bits[15:0]);
         FMT_U32: r.mag = bits;
         FMT_S8:  r.mag = bits[7] ? MAG_W'(9'h100 - {1'b0, bits[7:0]})
                                  : MAG_W'(bits[7:0]);
         FMT_S16: r.mag = bits[15] ? MAG_W'(17'h10000 - {1'b0, bits[15:0]})
                                   : MAG_W'(bits[15:0]);
         FMT_S32: r.mag = bits[31] ? (32'd0 - bits) : bits;
         FMT_F32: r = float_q230(bits);
         default: r.ok = 1'b0;
      endcase
      return r;
   endfunction

   // Register writes.
   always_ff @(posedge clock) begin
      if (reset) begin
         fmt_ff   <= FMT_INVALID;
         count_ff <= COUNT_RESET;
      end else if (csr_write) begin
         case (csr_reg_index)
            REG_SAMPLE_FORMAT: fmt_ff   <= format_type'(csr_write_data[FMT_W-1:0]);
            REG_CHANNEL_COUNT: count_ff <= csr_write_data[COUNT_W-1:0];
            default: ;
         endcase
      end
   end

   // Active channel count, clamped to 1..MAX_CHANNELS, and the channel of this item.
   always_comb begin
      if (count_ff == '0) begin
         active_n = CNT_W'(1);
      end else if (32'(count_ff) > MAX_CHANNELS) begin
         active_n = CNT_W'(MAX_CHANNELS);
      end else begin
         active_n = CNT_W'(count_ff);
      end
      eff_pos  = (CNT_W'(pos_ff) >= active_n) ? '0 : pos_ff;
      pos_plus = CNT_W'(eff_pos) + CNT_W'(1);
      pos_in   = (pos_plus >= active_n) ? '0 : POS_W'(pos_plus);
   end

   assign sample_mag = sample_magnitude(fmt_ff, sample_bits);

   // Channel position; it restarts at zero after an emit pass.
   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff <= '0;
      end else if (clear) begin
         pos_ff <= '0;
      end else if (cmd.accept) begin
         pos_ff <= pos_in;
      end
   end

   // Capture of the accepted item.
   always_ff @(posedge clock) begin
      if (cmd.accept) begin
         addr_ff <= eff_pos;
         mag_ff  <= sample_mag.mag;
         ok_ff   <= sample_mag.ok;
         last_ff <= end_of_buffer;
      end
   end

   // Read-modify-write of the channel max: the read is issued with the accept,
   // the compare and write happen in the following cycle.
   assign cur_max   = valid_ff[addr_ff] ? rd_ff : '0;
   assign upd_write = cmd.update && ok_ff && (mag_ff > cur_max);
   assign rd_addr   = cmd.emit_read ? emit_ff : eff_pos;
   assign clear     = cmd.out_load && emit_last;

   always_ff @(posedge clock) begin
      if (upd_write) begin
         channel_max_mem[addr_ff] <= mag_ff;
      end
      rd_ff <= channel_max_mem[rd_addr];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else if (clear) begin
         valid_ff <= '0;
      end else if (upd_write) begin
         valid_ff[addr_ff] <= 1'b1;
      end
   end

   // Emit channel counter.
   always_ff @(posedge clock) begin
      if (reset) begin
         emit_ff <= '0;
      end else if (cmd.emit_start) begin
         emit_ff <= '0;
      end else if (cmd.out_load && !emit_last) begin
         emit_ff <= emit_ff + POS_W'(1);
      end
   end

   assign emit_last = ((CNT_W'(emit_ff) + CNT_W'(1)) == active_n);
   assign emit_max  = valid_ff[emit_ff] ? rd_ff : '0;

   // Level numerator for the format in force.
   always_comb begin
      fs     = full_scale(fmt_ff);
      two_m  = {emit_max, 1'b0};
      fs_ext = {1'b0, fs};
      diff   = (two_m >= fs_ext) ? (two_m - fs_ext) : (fs_ext - two_m);
      case (fmt_ff)
         FMT_U8, FMT_U16, FMT_U32: num_in = NUM_W'(diff) << 16;
         FMT_S8, FMT_S16, FMT_S32: num_in = NUM_W'(emit_max) << 16;
         FMT_F32:                  num_in = NUM_W'(emit_max) * NUM_W'(FLOAT_SCALE);
         default:                  num_in = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (cmd.emit_num) begin
         num_ff <= num_in;
      end
   end

   // Restoring divider, one quotient bit per cycle, most significant first.
   assign trial = NUM_W'(fs) << step_ff;

   always_ff @(posedge clock) begin
      if (cmd.div_init) begin
         sat_ff  <= (num_ff >= sat_limit(fmt_ff));
         rem_ff  <= num_ff;
         q_ff    <= '0;
         step_ff <= STEP_W'(DIV_STEPS - 1);
      end else if (cmd.div_step) begin
         if (rem_ff >= trial) begin
            rem_ff <= rem_ff - trial;
            q_ff   <= {q_ff[LEVEL_W-2:0], 1'b1};
         end else begin
            q_ff   <= {q_ff[LEVEL_W-2:0], 1'b0};
         end
         step_ff <= step_ff - STEP_W'(1);
      end
   end

   assign level     = (fmt_ff == FMT_INVALID) ? '0 : (sat_ff ? LEVEL_ONE : q_ff);
   assign emit_wide = {{INDEX_W{1'b0}}, emit_ff};

   // Output register; it is refilled in the cycle the waiting item is taken.
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.out_load) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.out_load) begin
         index_ff    <= emit_wide[INDEX_W-1:0];
         level_ff    <= level;
         last_out_ff <= emit_last;
      end
   end

   assign rsp_valid     = rsp_valid_ff;
   assign channel_index = index_ff;
   assign peak_level    = level_ff;
   assign last_level    = last_out_ff;

   // Status to the controller.
   always_comb begin
      status.last_item = last_ff;
      status.emit_last = emit_last;
      status.div_last  = (step_ff == '0);
      status.out_free  = !rsp_valid_ff || rsp_ready;
   end

endmodule

@@ design/multichannel_audio_peak_meter.sv @@
// Top level of the multichannel audio peak meter: controller, datapath and channel ports.
// Depends on mapm_pkg, the channel interfaces, mapm_controller and mapm_datapath.
//
//   channel   direction  payload                                   handshake
//   req_port  in         sample_bits[31:0], end_of_buffer          valid/ready
//   rsp_port  out        channel_index[2:0], peak_level[16:0],     valid/ready
//                        last_level
//   csr_port  in         reg_index[3:0] (0 format, 1 count),       valid/ready
//                        write_data[31:0]
//
// The accept cycle of a sample item reads the channel max memory, and the next cycle
// compares the maximum and writes it back; the input is not ready in that update cycle.
// An end-of-buffer item then emits one level per active channel, each through read,
// numerator, saturation check, 17 divider steps and output load; rsp stalls delay the load.
// The output register frees the input side as soon as the last level is loaded.
// Reset is synchronous: format invalid, 2 channels, all maxima and the position cleared.
// Register writes are always taken; csr_port.ready is held high.

module multichannel_audio_peak_meter #(
   parameter int MAX_CHANNELS = 8
) (
   input logic       clock,
   input logic       reset,
   mapm_req_if.sink  req_port,
   mapm_rsp_if.source rsp_port,
   mapm_csr_if.sink  csr_port
);
   import mapm_pkg::*;

   ctrl_cmd_type    cmd;
   ctrl_status_type status;
   logic            req_ready;
   logic            csr_write;

   assign csr_port.ready = 1'b1;
   assign csr_write      = csr_port.valid && csr_port.ready;
   assign req_port.ready = req_ready;

   mapm_controller u_controller (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_port.valid),
      .req_ready (req_ready),
      .status    (status),
      .cmd       (cmd)
   );

   mapm_datapath #(
      .MAX_CHANNELS (MAX_CHANNELS)
   ) u_datapath (
      .clock          (clock),
      .reset          (reset),
      .cmd            (cmd),
      .status         (status),
      .sample_bits    (req_port.sample_bits),
      .end_of_buffer  (req_port.end_of_buffer),
      .csr_write      (csr_write),
      .csr_reg_index  (csr_port.reg_index),
      .csr_write_data (csr_port.write_data),
      .rsp_ready      (rsp_port.ready),
      .rsp_valid      (rsp_port.valid),
      .channel_index  (rsp_port.channel_index),
      .peak_level     (rsp_port.peak_level),
      .last_level     (rsp_port.last_level)
   );

endmodule

@@ design/mapm_checker.sv @@
// Port-level checks of the peak meter, attached to the top level by a bind statement.
// Depends on mapm_pkg and on multichannel_audio_peak_meter.

module mapm_checker (
   input logic                          clock,
   input logic                          reset,
   input logic                          req_valid,
   input logic                          req_ready,
   input logic                          rsp_valid,
   input logic                          rsp_ready,
   input logic [mapm_pkg::INDEX_W-1:0]  channel_index,
   input logic [mapm_pkg::LEVEL_W-1:0]  peak_level,
   input logic                          last_level
);
   import mapm_pkg::*;

   // A waiting result item holds its payload until it is taken.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(channel_index)
                                  && $stable(peak_level) && $stable(last_level))
      else $error("result item changed while stalled");

   // Reset leaves the block ready for samples with no result pending.
   assert property (@(posedge clock) reset |=> req_ready && !rsp_valid)
      else $error("block not idle after reset");

   // The input is not ready during the max update that follows an accepted sample.
   assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("sample accepted in the update cycle");

   // While a non-final level is shown, the emit pass still holds the input off.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !last_level |-> !req_ready)
      else $error("input opened during the emit pass");

   // Levels saturate at 1.0.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> peak_level <= LEVEL_ONE)
      else $error("level above full scale");

endmodule

bind multichannel_audio_peak_meter mapm_checker u_mapm_checker (
   .clock         (clock),
   .reset         (reset),
   .req_valid     (req_port.valid),
   .req_ready     (req_port.ready),
   .rsp_valid     (rsp_port.valid),
   .rsp_ready     (rsp_port.ready),
   .channel_index (rsp_port.channel_index),
   .peak_level    (rsp_port.peak_level),
   .last_level    (rsp_port.last_level)
);

@@ dv/peak_level_check.sv @@
// Scoreboard of the multichannel audio peak meter: predicts the per-channel levels and
// compares them with the result channel. Depends on mapm_pkg and the channel interfaces.

module peak_level_check (
   input  logic clock,
   input  logic reset,
   mapm_req_if  req_mon,
   mapm_rsp_if  rsp_mon,
   mapm_csr_if  csr_mon,
   output int   mismatch_count,
   output int   levels_outstanding
);
   import mapm_pkg::*;

   localparam int MAX_CHANNELS = 8;
   localparam int REPORT_LIMIT = 10;

   typedef struct packed {
      logic [INDEX_W-1:0] channel;
      logic [LEVEL_W-1:0] level;
      logic               last_flag;
   } level_item_t;

   // Shadow copy of the registers and the per-channel peak memory.
   format_type         fmt_now;
   logic [COUNT_W-1:0] count_now;
   logic [MAG_W-1:0]   peak_max [MAX_CHANNELS];
   int                 position;
   level_item_t        expected_levels [$];
   int                 errors;

   // Counts of 0 behave as one channel, counts above the maximum as the maximum.
   function automatic int active_count(input logic [COUNT_W-1:0] count);
      if (count == 0) return 1;
      if (count > MAX_CHANNELS) return MAX_CHANNELS;
      return int'(count);
   endfunction

   // Float magnitude in unsigned Q2.30; NaN is flagged as unusable.
   function automatic magnitude_type float_q230(input logic [SAMPLE_W-1:0] bits);
      magnitude_type r;
      logic [63:0]   sig;
      int            shift;
      r.ok  = 1'b1;
      r.mag = '0;
      sig   = {40'd0, 1'b1, bits[22:0]};
      shift = int'(bits[30:23]) - 120;
      if (bits[30:23] == 8'hFF) begin
         r.ok  = (bits[22:0] == 23'd0);
         r.mag = r.ok ? 32'hFFFF_FFFF : 32'd0;
      end else if (bits[30:23] == 8'h00) begin
         r.mag = '0;
      end else if (shift > 8) begin
         r.mag = 32'hFFFF_FFFF;
      end else if (shift >= 0) begin
         sig   = sig << shift;
         r.mag = (sig > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : sig[31:0];
      end else if (shift > -32) begin
         sig   = sig >> (-shift);
         r.mag = sig[31:0];
      end
      return r;
   endfunction

   // Magnitude of one sample in the given format.
   function automatic magnitude_type sample_magnitude(input format_type fmt,
                                                      input logic [SAMPLE_W-1:0] bits);
      magnitude_type r;
      r.ok  = 1'b1;
      r.mag = '0;
      case (fmt)
         FMT_U8:  r.mag = {24'd0, bits[7:0]};
         FMT_U16: r.mag = {16'd0, bits[15:0]};
         FMT_U32: r.mag = bits;
         FMT_S8:  r.mag = bits[7] ? 32'h100 - {24'd0, bits[7:0]} : {24'd0, bits[7:0]};
         FMT_S16: r.mag = bits[15] ? 32'h10000 - {16'd0, bits[15:0]} : {16'd0, bits[15:0]};
         FMT_S32: r.mag = bits[31] ? 32'd0 - bits : bits;
         FMT_F32: r = float_q230(bits);
         default: r.ok = 1'b0;
      endcase
      return r;
   endfunction

   // Normalized Q1.16 level of a stored maximum, saturated at 1.0.
   function automatic logic [LEVEL_W-1:0] level_from_max(input format_type fmt,
                                                         input logic [MAG_W-1:0] m);
      logic [63:0] scale;
      logic [63:0] num;
      logic [63:0] quot;
      quot = '0;
      case (fmt)
         FMT_U8, FMT_U16, FMT_U32: begin
            scale = (fmt == FMT_U8) ? 64'd255 : (fmt == FMT_U16) ? 64'd65535 : 64'hFFFF_FFFF;
            num   = {31'd0, m, 1'b0};
            num   = (num >= scale) ? num - scale : scale - num;
            quot  = (num << 16) / scale;
         end
         FMT_S8, FMT_S16, FMT_S32: begin
            scale = (fmt == FMT_S8) ? 64'd127 : (fmt == FMT_S16) ? 64'd32767 : 64'h7FFF_FFFF;
            quot  = ({32'd0, m} << 16) / scale;
         end
         FMT_F32: quot = ({32'd0, m} * 64'd100000) / (64'd100003 << 14);
         default: quot = '0;
      endcase
      return (quot > 64'd65536) ? LEVEL_ONE : quot[LEVEL_W-1:0];
   endfunction

   always @(posedge clock) begin : track
      magnitude_type mag;
      level_item_t   got;
      level_item_t   want;
      int            n;
      if (reset) begin
         fmt_now   = FMT_INVALID;
         count_now = COUNT_RESET;
         for (int ch = 0; ch < MAX_CHANNELS; ch++) peak_max[ch] = '0;
         position = 0;
         expected_levels.delete();
         errors = 0;
      end else begin
         // Register writes update the shadow configuration.
         if (csr_mon.valid && csr_mon.ready) begin
            if (csr_mon.reg_index == REG_SAMPLE_FORMAT) begin
               fmt_now = format_type'(csr_mon.write_data[FMT_W-1:0]);
            end else if (csr_mon.reg_index == REG_CHANNEL_COUNT) begin
               count_now = csr_mon.write_data[COUNT_W-1:0];
            end
         end

         // Each accepted sample item updates its channel; end of buffer emits all levels.
         if (req_mon.valid && req_mon.ready) begin
            n = active_count(count_now);
            if (position >= n) position = 0;
            mag = sample_magnitude(fmt_now, req_mon.sample_bits);
            if (mag.ok && mag.mag > peak_max[position]) peak_max[position] = mag.mag;
            position = (position + 1 >= n) ? 0 : position + 1;
            if (req_mon.end_of_buffer) begin
               for (int ch = 0; ch < n; ch++) begin
                  want.channel   = ch[INDEX_W-1:0];
                  want.level     = level_from_max(fmt_now, peak_max[ch]);
                  want.last_flag = (ch + 1 == n);
                  expected_levels.push_back(want);
               end
               for (int ch = 0; ch < MAX_CHANNELS; ch++) peak_max[ch] = '0;
               position = 0;
            end
         end

         // Each accepted result item is checked against the oldest prediction.
         if (rsp_mon.valid && rsp_mon.ready) begin
            got.channel   = rsp_mon.channel_index;
            got.level     = rsp_mon.peak_level;
            got.last_flag = rsp_mon.last_level;
            if (expected_levels.size() == 0) begin
               errors++;
               if (errors <= REPORT_LIMIT) begin
                  $display("unexpected level item: ch %0d level %0d last %0b",
                           got.channel, got.level, got.last_flag);
               end
            end else begin
               want = expected_levels.pop_front();
               if (got != want) begin
                  errors++;
                  if (errors <= REPORT_LIMIT) begin
                     $display("level mismatch: expected ch %0d level %0d last %0b, got ch %0d level %0d last %0b",
                              want.channel, want.level, want.last_flag,
                              got.channel, got.level, got.last_flag);
                  end
               end
            end
         end
      end
      mismatch_count     <= errors;
      levels_outstanding <= expected_levels.size();
   end

endmodule

@@ dv/tb.sv @@
// Top of the peak meter testbench: clock, reset, sample and register stimulus, verdict.
// Depends on mapm_pkg, the channel interfaces, the block and peak_level_check.

module tb;
   import mapm_pkg::*;

   localparam int RANDOM_ITEMS = 360;
   localparam int IDLE_PCT     = 12;
   localparam int SETTLE_GAP   = 8;
   localparam int HOLD_CYCLES  = 400;
   localparam int DRAIN_LIMIT  = 100000;
   localparam int TAIL_CYCLES  = 200;
   localparam int PRESSURE_PHASE = 3;
   localparam int CALM_PHASE     = 6;

   logic clock = 1'b0;
   logic reset;
   int   sent_items  = 0;
   bit   calm        = 1'b0;
   int   hold_serial = 0;
   int   mismatch_count;
   int   levels_outstanding;

   mapm_req_if req_if ();
   mapm_rsp_if rsp_if ();
   mapm_csr_if csr_if ();

   multichannel_audio_peak_meter dut (
      .clock    (clock),
      .reset    (reset),
      .req_port (req_if),
      .rsp_port (rsp_if),
      .csr_port (csr_if)
   );

   peak_level_check level_check (
      .clock              (clock),
      .reset              (reset),
      .req_mon            (req_if),
      .rsp_mon            (rsp_if),
      .csr_mon            (csr_if),
      .mismatch_count     (mismatch_count),
      .levels_outstanding (levels_outstanding)
   );

   always #5 clock = ~clock;

   // Offer one sample item, with random idle cycles ahead of it.
   task automatic send_sample(input logic [SAMPLE_W-1:0] bits, input logic eob);
      while (!calm && $urandom_range(0, 99) < IDLE_PCT) begin
         req_if.valid <= 1'b0;
         @(posedge clock);
      end
      req_if.valid         <= 1'b1;
      req_if.sample_bits   <= bits;
      req_if.end_of_buffer <= eob;
      @(posedge clock);
      while (!req_if.ready) @(posedge clock);
      sent_items++;
   endtask

   // Stop offering and wait until every predicted level has come and the block is quiet.
   task automatic wait_idle();
      req_if.valid <= 1'b0;
      @(posedge clock);
      while (levels_outstanding != 0) @(posedge clock);
      repeat (SETTLE_GAP) @(posedge clock);
   endtask

   // One register write; valid stays high so that writes can follow back to back.
   task automatic write_reg(input logic [REG_INDEX_W-1:0] idx,
                            input logic [CSR_DATA_W-1:0] data);
      csr_if.valid      <= 1'b1;
      csr_if.reg_index  <= idx;
      csr_if.write_data <= data;
      @(posedge clock);
      while (!csr_if.ready) @(posedge clock);
   endtask

   // Program format and channel count while idle; unused bits carry random data.
   task automatic configure(input format_type fmt, input logic [COUNT_W-1:0] count);
      logic [CSR_DATA_W-1:0] fmt_word;
      logic [CSR_DATA_W-1:0] count_word;
      fmt_word   = $urandom;
      count_word = $urandom;
      fmt_word[FMT_W-1:0]     = fmt;
      count_word[COUNT_W-1:0] = count;
      wait_idle();
      if ($urandom_range(0, 1)) begin
         write_reg(REG_SAMPLE_FORMAT, fmt_word);
         write_reg(REG_CHANNEL_COUNT, count_word);
      end else begin
         write_reg(REG_CHANNEL_COUNT, count_word);
         write_reg(REG_SAMPLE_FORMAT, fmt_word);
      end
      // Now and then an index that maps to no register.
      if ($urandom_range(0, 7) == 0) begin
         write_reg(REG_INDEX_W'($urandom_range(int'(REG_CHANNEL_COUNT) + 1,
                                               (1 << REG_INDEX_W) - 1)), $urandom);
      end
      csr_if.valid <= 1'b0;
   endtask

   // Random sample: raw noise, full-scale corners, or values shaped for the format.
   function automatic logic [SAMPLE_W-1:0] pick_sample(input format_type fmt);
      logic [SAMPLE_W-1:0] v;
      logic [SAMPLE_W-1:0] r;
      logic [7:0]          ex;
      r = $urandom;
      case ($urandom_range(0, 9))
         0, 1, 2: v = r;
         3: begin
            case ($urandom_range(0, 9))
               0:       v = 32'h0000_0000;
               1:       v = 32'hFFFF_FFFF;
               2:       v = 32'h8000_0000;
               3:       v = 32'h7FFF_FFFF;
               4:       v = 32'h0000_0080;
               5:       v = 32'h0000_007F;
               6:       v = 32'h0000_8000;
               7:       v = 32'h0000_7FFF;
               8:       v = 32'h7F80_0000;
               default: v = 32'hFF80_0000;
            endcase
         end
         default: begin
            if (fmt == FMT_F32) begin
               if ($urandom_range(0, 19) == 0) ex = $urandom_range(0, 1) ? 8'hFF : 8'h00;
               else ex = 8'($urandom_range(110, 130));
               v = {r[31], ex, r[22:0]};
            end else begin
               v = r >> $urandom_range(0, 31);
               if ($urandom_range(0, 1)) v = 32'd0 - v;
            end
         end
      endcase
      return v;
   endfunction

   // Result side: random back-pressure, plus one long hold-off on request.
   initial begin : result_sink
      int hold_seen;
      int hold_left;
      hold_seen = 0;
      hold_left = 0;
      rsp_if.ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (hold_left > 0) begin
            rsp_if.ready <= 1'b0;
            hold_left--;
         end else if (hold_serial != hold_seen) begin
            hold_seen    = hold_serial;
            hold_left    = HOLD_CYCLES;
            rsp_if.ready <= 1'b0;
         end else begin
            rsp_if.ready <= calm || ($urandom_range(0, 99) >= IDLE_PCT);
         end
      end
   end

   // Watchdog for a hung run.
   initial begin : watchdog
      #5000000;
      $display("SCOREBOARD MISMATCH");
      $finish;
   end

   initial begin : stimulus
      format_type         fmt;
      logic [COUNT_W-1:0] count;
      int                 phase;
      int                 buffers;
      int                 len;
      int                 item_goal;
      int                 drain_cycles;
      logic               eob;

      reset                <= 1'b1;
      req_if.valid         <= 1'b0;
      req_if.sample_bits   <= '0;
      req_if.end_of_buffer <= 1'b0;
      csr_if.valid         <= 1'b0;
      csr_if.reg_index     <= '0;
      csr_if.write_data    <= '0;
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Reset settings: invalid format over two channels gives zero levels.
      send_sample(32'hFFFF_FFFF, 1'b0);
      send_sample(32'h1234_5678, 1'b1);

      // u8 on one channel: full scale at the bottom code, then a near-midscale peak.
      configure(FMT_U8, 4'd1);
      send_sample(32'h0000_0000, 1'b1);
      send_sample(32'hFFFF_FF80, 1'b1);

      // s8 on eight channels: most negative, most positive, end in mid-frame.
      configure(FMT_S8, 4'd8);
      send_sample(32'h0000_0080, 1'b0);
      send_sample(32'h0000_007F, 1'b0);
      send_sample(32'h0000_0001, 1'b0);
      send_sample(32'h0000_00FF, 1'b1);

      // s16 with a count above the maximum.
      configure(FMT_S16, 4'd15);
      send_sample(32'h0000_8000, 1'b0);
      send_sample(32'hABCD_7FFF, 1'b1);

      // s32 corners on three channels, wrapping back to channel 0.
      configure(FMT_S32, 4'd3);
      send_sample(32'h8000_0000, 1'b0);
      send_sample(32'h7FFF_FFFF, 1'b0);
      send_sample(32'h0000_0000, 1'b0);
      send_sample(32'hFFFF_FFFF, 1'b1);

      // Float: NaN, infinity, denormal, negative one, two and one half.
      configure(FMT_F32, 4'd4);
      send_sample(32'h7FC0_0000, 1'b0);
      send_sample(32'h7F80_0000, 1'b0);
      send_sample(32'h0000_0001, 1'b0);
      send_sample(32'hBF80_0000, 1'b0);
      send_sample(32'h4000_0000, 1'b0);
      send_sample(32'h3F00_0000, 1'b1);

      // u16 with a count of zero, which acts as one channel.
      configure(FMT_U16, 4'd0);
      send_sample(32'h0000_FFFF, 1'b0);
      send_sample(32'h0000_8000, 1'b1);

      // u32, then count and format changed in the middle of the buffer.
      configure(FMT_U32, 4'd2);
      send_sample(32'hFFFF_FFFF, 1'b0);
      send_sample(32'h8000_0000, 1'b0);
      send_sample(32'h7FFF_FFFF, 1'b0);
      configure(FMT_U8, 4'd1);
      send_sample(32'h0000_00FF, 1'b1);

      // Random phases; a phase may stop short of end of buffer and carry it over.
      item_goal = sent_items + RANDOM_ITEMS;
      phase     = 0;
      while (sent_items < item_goal) begin
         phase++;
         fmt = format_type'($urandom_range(0, 7));
         case ($urandom_range(0, 9))
            0:       count = COUNT_W'($urandom_range(0, (1 << COUNT_W) - 1));
            1:       count = 4'd1;
            2:       count = 4'd8;
            default: count = COUNT_W'($urandom_range(1, 8));
         endcase
         if (phase == PRESSURE_PHASE) count = 4'd8;
         configure(fmt, count);
         calm = (phase == CALM_PHASE);

         // The pressure phase fills the block with short buffers while results are held.
         if (phase == PRESSURE_PHASE) begin
            hold_serial++;
            buffers = 8;
         end else begin
            buffers = $urandom_range(1, 4);
         end
         for (int b = 0; b < buffers; b++) begin
            if (phase == PRESSURE_PHASE) len = $urandom_range(1, 3);
            else len = $urandom_range(1, 3 * int'(count) + 1);
            for (int i = 0; i < len; i++) begin
               eob = (i == len - 1) && !(b == buffers - 1 && $urandom_range(0, 7) == 0);
               send_sample(pick_sample(fmt), eob);
            end
         end
         calm = 1'b0;
      end

      // Drain the remaining levels, then give the block time to show any stray item.
      req_if.valid <= 1'b0;
      @(posedge clock);
      drain_cycles = 0;
      while (levels_outstanding != 0 && drain_cycles < DRAIN_LIMIT) begin
         @(posedge clock);
         drain_cycles++;
      end
      repeat (TAIL_CYCLES) @(posedge clock);

      if (mismatch_count == 0 && levels_outstanding == 0) begin
         $display("SCOREBOARD CLEAN");
      end else begin
         $display("SCOREBOARD MISMATCH");
      end
      $finish;
   end

endmodule
